// File: design/sfp_pkg.sv
// Shared constants, register codes and types for the frame parser.
`default_nettype none

package sfp_pkg;

    // Payload store depth default and header overhead (two start, type, length, checksum)
    localparam int FRAME_BYTES_DEF = 64;
    localparam int HEADER_BYTES    = 5;
    localparam int PAYLOAD_LIMIT   = 59;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;

    // Register reset values
    localparam logic [BYTE_W-1:0] START_FIRST_RST  = 8'hA5;
    localparam logic [BYTE_W-1:0] START_SECOND_RST = 8'h5A;
    localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST  = 6'd58;

    // APB register map
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_START_FIRST  = 2'd0;
    localparam logic [1:0] REG_START_SECOND = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd2;

    // Configuration seen by the parser
    typedef struct packed {
        logic [BYTE_W-1:0] start_first;
        logic [BYTE_W-1:0] start_second;
        logic [LEN_W-1:0]  max_payload;
    } t_cfg;

endpackage

`default_nettype wire

// File: design/sfp_buf.sv
// Payload store: one write port, one read port with registered read data.
`default_nettype none

module sfp_buf #(
    parameter int DEPTH = sfp_pkg::FRAME_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [sfp_pkg::BYTE_W-1:0] i_wdata,
    input  wire logic                      i_re,
    input  wire logic [AW-1:0]             i_raddr,
    output logic      [sfp_pkg::BYTE_W-1:0] o_rdata
);

    logic [sfp_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [sfp_pkg::BYTE_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/sfp_ctrl.sv
// Frame parser sequencer: header/payload tracking, store writes and result drain.
`default_nettype none

module sfp_ctrl #(
    parameter int FRAME_BYTES = sfp_pkg::FRAME_BYTES_DEF,
    parameter int AW          = $clog2(FRAME_BYTES)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire sfp_pkg::t_cfg               i_cfg,
    // input item
    input  wire logic                        i_rx_valid,
    output logic                             o_rx_ready,
    input  wire logic [sfp_pkg::BYTE_W-1:0]  i_rx_byte,
    // result item
    output logic                             o_res_valid,
    input  wire logic                        i_res_ready,
    output logic      [sfp_pkg::BYTE_W-1:0]  o_frame_type,
    output logic      [sfp_pkg::LEN_W-1:0]   o_payload_length,
    output logic      [sfp_pkg::LEN_W-1:0]   o_byte_index,
    output logic      [sfp_pkg::BYTE_W-1:0]  o_payload_byte,
    output logic                             o_has_byte,
    output logic                             o_last,
    // payload store
    output logic                             o_mem_we,
    output logic      [AW-1:0]               o_mem_waddr,
    output logic      [sfp_pkg::BYTE_W-1:0]  o_mem_wdata,
    output logic                             o_mem_re,
    output logic      [AW-1:0]               o_mem_raddr,
    input  wire logic [sfp_pkg::BYTE_W-1:0]  i_mem_rdata
);

    localparam int ROOM    = FRAME_BYTES - sfp_pkg::HEADER_BYTES;
    localparam int CAP     = (ROOM < sfp_pkg::PAYLOAD_LIMIT) ? ROOM : sfp_pkg::PAYLOAD_LIMIT;
    localparam logic [sfp_pkg::LEN_W-1:0] CAP_LEN = sfp_pkg::LEN_W'(CAP);

    typedef enum logic [5:0] {
        ST_HUNT  = 6'b000001,
        ST_SOF2  = 6'b000010,
        ST_TYPE  = 6'b000100,
        ST_LEN   = 6'b001000,
        ST_BODY  = 6'b010000,
        ST_DRAIN = 6'b100000
    } t_state;

    t_state                     r_state, n_state;
    logic [sfp_pkg::BYTE_W-1:0] r_type, n_type;
    logic [sfp_pkg::LEN_W-1:0]  r_len, n_len;
    logic [sfp_pkg::BYTE_W-1:0] r_xor, n_xor;
    logic [sfp_pkg::LEN_W-1:0]  r_cnt, n_cnt;

    // read stage (memory data register alongside)
    logic                       r_s1_v, n_s1_v;
    logic [sfp_pkg::LEN_W-1:0]  r_s1_idx;
    logic                       r_s1_has;
    logic                       r_s1_last;

    // output register
    logic                       r_o_valid, n_o_valid;
    logic [sfp_pkg::BYTE_W-1:0] r_o_type;
    logic [sfp_pkg::LEN_W-1:0]  r_o_len;
    logic [sfp_pkg::LEN_W-1:0]  r_o_idx;
    logic [sfp_pkg::BYTE_W-1:0] r_o_byte;
    logic                       r_o_has;
    logic                       r_o_last;

    logic                       w_in_acc;
    logic                       w_s1_move;
    logic                       w_issue;
    logic [sfp_pkg::LEN_W-1:0]  w_eff_max;
    logic [sfp_pkg::LEN_W-1:0]  w_total;
    logic [sfp_pkg::LEN_W-1:0]  w_last_idx;
    logic                       w_issue_last;

    // input is blocked while a run is read out of the store
    assign o_rx_ready = (r_state != ST_DRAIN) && !r_s1_v;
    assign w_in_acc   = i_rx_valid && o_rx_ready;

    // saturated length limit
    assign w_eff_max = (i_cfg.max_payload > CAP_LEN) ? CAP_LEN : i_cfg.max_payload;

    // drain bookkeeping: an empty payload still gives one result
    assign w_total      = (r_len == '0) ? sfp_pkg::LEN_W'(1) : r_len;
    assign w_last_idx   = w_total - sfp_pkg::LEN_W'(1);
    assign w_s1_move    = r_s1_v && (!r_o_valid || i_res_ready);
    assign w_issue      = (r_state == ST_DRAIN) && (!r_s1_v || w_s1_move);
    assign w_issue_last = (r_cnt == w_last_idx);

    // store ports
    assign o_mem_we    = w_in_acc && (r_state == ST_BODY) && (r_cnt < r_len);
    assign o_mem_waddr = AW'(r_cnt);
    assign o_mem_wdata = i_rx_byte;
    assign o_mem_re    = w_issue && (r_len != '0);
    assign o_mem_raddr = AW'(r_cnt);

    // parse and drain sequencing
    always_comb begin
        n_state = r_state;
        n_type  = r_type;
        n_len   = r_len;
        n_xor   = r_xor;
        n_cnt   = r_cnt;
        case (r_state)
            ST_HUNT: begin
                if (w_in_acc && (i_rx_byte == i_cfg.start_first)) begin
                    n_state = ST_SOF2;
                end
            end
            ST_SOF2: begin
                if (w_in_acc) begin
                    n_state = (i_rx_byte == i_cfg.start_second) ? ST_TYPE : ST_HUNT;
                end
            end
            ST_TYPE: begin
                if (w_in_acc) begin
                    n_type  = i_rx_byte;
                    n_xor   = i_rx_byte;
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                if (w_in_acc) begin
                    if (i_rx_byte > {2'b00, w_eff_max}) begin
                        n_state = ST_HUNT;
                    end else begin
                        n_len   = i_rx_byte[sfp_pkg::LEN_W-1:0];
                        n_xor   = r_xor ^ i_rx_byte;
                        n_cnt   = '0;
                        n_state = ST_BODY;
                    end
                end
            end
            ST_BODY: begin
                if (w_in_acc) begin
                    if (r_cnt < r_len) begin
                        n_xor = r_xor ^ i_rx_byte;
                        n_cnt = r_cnt + sfp_pkg::LEN_W'(1);
                    end else if (i_rx_byte == r_xor) begin
                        // checksum good: read the run back out
                        n_cnt   = '0;
                        n_state = ST_DRAIN;
                    end else begin
                        n_state = ST_HUNT;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_issue) begin
                    if (w_issue_last) begin
                        n_state = ST_HUNT;
                    end else begin
                        n_cnt = r_cnt + sfp_pkg::LEN_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    // stage valids
    always_comb begin
        n_s1_v = r_s1_v;
        if (w_issue) begin
            n_s1_v = 1'b1;
        end else if (w_s1_move) begin
            n_s1_v = 1'b0;
        end
        n_o_valid = r_o_valid;
        if (w_s1_move) begin
            n_o_valid = 1'b1;
        end else if (i_res_ready) begin
            n_o_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_HUNT;
            r_type    <= '0;
            r_len     <= '0;
            r_xor     <= '0;
            r_cnt     <= '0;
            r_s1_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_type    <= n_type;
            r_len     <= n_len;
            r_xor     <= n_xor;
            r_cnt     <= n_cnt;
            r_s1_v    <= n_s1_v;
            r_o_valid <= n_o_valid;
        end
    end

    // payload of the read stage and the output register
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s1_idx  <= r_cnt;
            r_s1_has  <= (r_len != '0);
            r_s1_last <= w_issue_last;
        end
        if (w_s1_move) begin
            r_o_type <= r_type;
            r_o_len  <= r_len;
            r_o_idx  <= r_s1_idx;
            r_o_byte <= r_s1_has ? i_mem_rdata : '0;
            r_o_has  <= r_s1_has;
            r_o_last <= r_s1_last;
        end
    end

    assign o_res_valid      = r_o_valid;
    assign o_frame_type     = r_o_type;
    assign o_payload_length = r_o_len;
    assign o_byte_index     = r_o_idx;
    assign o_payload_byte   = r_o_byte;
    assign o_has_byte       = r_o_has;
    assign o_last           = r_o_last;

`ifndef SYNTHESIS
    // no store write may land while a read is still in flight
    a_no_write_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v || (r_state == ST_DRAIN)) |-> !o_mem_we)
        else $error("payload store written during readout");

    // good checksum always starts a readout
    a_good_sum_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (r_state == ST_BODY) && (r_cnt == r_len) && (i_rx_byte == r_xor))
        |=> (r_state == ST_DRAIN) && (r_cnt == '0))
        else $error("good frame did not enter readout");

    // an item without a byte is only the lone result of an empty frame
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_has) |-> (r_o_len == '0) && r_o_last && (r_o_idx == '0))
        else $error("empty result malformed");

    // byte index stays inside the payload, last on the final byte
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_has) |->
            (r_o_idx < r_o_len) && (r_o_last == (r_o_idx == r_o_len - sfp_pkg::LEN_W'(1))))
        else $error("result index out of range");

    // payload counter never passes the held length
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_BODY) || (r_state == ST_DRAIN)) |-> (r_cnt <= r_len))
        else $error("payload counter overran length");
`endif

endmodule

`default_nettype wire

// File: design/sof_length_xor_frame_parser_unit.sv
// Top level of the start-of-frame / length / XOR checksum frame parser.
// The first result of a good frame passes the readout state, read stage and output
// register after its checksum item. One byte per cycle while a frame is received and
// input is not held off; a good frame's n results (1 if empty) drain one per cycle from
// the store read port while taken; input is held off until the last read moves on.
// Reset: synchronous, active low; no clearing pass, payload store is not cleared.
`default_nettype none

module sof_length_xor_frame_parser_unit #(
    parameter int FRAME_BYTES = sfp_pkg::FRAME_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sfp_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [sfp_pkg::PDATA_W-1:0]   pwdata,
    output logic      [sfp_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    // received bytes
    input  wire logic                          i_rx_valid,
    output logic                               o_rx_ready,
    input  wire logic [sfp_pkg::BYTE_W-1:0]    i_rx_byte,
    // results
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output logic      [sfp_pkg::BYTE_W-1:0]    o_frame_type,
    output logic      [sfp_pkg::LEN_W-1:0]     o_payload_length,
    output logic      [sfp_pkg::LEN_W-1:0]     o_byte_index,
    output logic      [sfp_pkg::BYTE_W-1:0]    o_payload_byte,
    output logic                               o_has_byte,
    output logic                               o_last
);

    localparam int AW = $clog2(FRAME_BYTES);

    sfp_pkg::t_cfg               r_cfg;
    logic [1:0]                  w_reg_idx;
    logic                        w_wr;

    logic                        w_mem_we;
    logic [AW-1:0]               w_mem_waddr;
    logic [sfp_pkg::BYTE_W-1:0]  w_mem_wdata;
    logic                        w_mem_re;
    logic [AW-1:0]               w_mem_raddr;
    logic [sfp_pkg::BYTE_W-1:0]  w_mem_rdata;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_wr      = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_first  <= sfp_pkg::START_FIRST_RST;
            r_cfg.start_second <= sfp_pkg::START_SECOND_RST;
            r_cfg.max_payload  <= sfp_pkg::MAX_PAYLOAD_RST;
        end else if (w_wr) begin
            case (w_reg_idx)
                sfp_pkg::REG_START_FIRST:  r_cfg.start_first  <= pwdata[sfp_pkg::BYTE_W-1:0];
                sfp_pkg::REG_START_SECOND: r_cfg.start_second <= pwdata[sfp_pkg::BYTE_W-1:0];
                sfp_pkg::REG_MAX_PAYLOAD:  r_cfg.max_payload  <= pwdata[sfp_pkg::LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (w_reg_idx)
            sfp_pkg::REG_START_FIRST:  prdata = sfp_pkg::PDATA_W'(r_cfg.start_first);
            sfp_pkg::REG_START_SECOND: prdata = sfp_pkg::PDATA_W'(r_cfg.start_second);
            sfp_pkg::REG_MAX_PAYLOAD:  prdata = sfp_pkg::PDATA_W'(r_cfg.max_payload);
            default:                   prdata = '0;
        endcase
    end

    sfp_ctrl #(
        .FRAME_BYTES (FRAME_BYTES),
        .AW          (AW)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_rx_valid       (i_rx_valid),
        .o_rx_ready       (o_rx_ready),
        .i_rx_byte        (i_rx_byte),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_frame_type     (o_frame_type),
        .o_payload_length (o_payload_length),
        .o_byte_index     (o_byte_index),
        .o_payload_byte   (o_payload_byte),
        .o_has_byte       (o_has_byte),
        .o_last           (o_last),
        .o_mem_we         (w_mem_we),
        .o_mem_waddr      (w_mem_waddr),
        .o_mem_wdata      (w_mem_wdata),
        .o_mem_re         (w_mem_re),
        .o_mem_raddr      (w_mem_raddr),
        .i_mem_rdata      (w_mem_rdata)
    );

    sfp_buf #(
        .DEPTH (FRAME_BYTES),
        .AW    (AW)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

endmodule

`default_nettype wire
